// ----- design/slrr_pkg.sv -----
// ----------------------------------------------------------------------------
// slrr_pkg
// Shared constants and types of the shuffled Park-Miller range generator.
// ----------------------------------------------------------------------------
package slrr_pkg;

  // Park-Miller minimal standard generator
  localparam logic [14:0] PM_MULT      = 15'd16807;
  localparam logic [30:0] PM_MOD       = 31'h7FFF_FFFF;
  localparam int          WARMUP_EXTRA = 8;

  // 2^31, the dividend of the rejection limit
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  // remainder unit width
  localparam int DIV_BITS = 32;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } slrr_div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] remainder;
  } slrr_div_rsp_t;

endpackage

// ----- design/slrr_intf.sv -----
// ----------------------------------------------------------------------------
// slrr channel interfaces
// Valid/ready channels for requests, results and the seed register.
// ----------------------------------------------------------------------------
interface slrr_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, range_low, range_high, input ready);
  modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface slrr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

interface slrr_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

// ----- design/slrr_rem.sv -----
// ----------------------------------------------------------------------------
// slrr_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module slrr_rem import slrr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slrr_div_req_t req_i,
  output slrr_div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_BITS + 1);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DIV_BITS-1:0] dvd_q;
  logic [DIV_BITS-1:0] rem_q;
  logic                done_q;

  logic [DIV_BITS:0]   trial_d;
  logic [DIV_BITS:0]   sub_d;
  logic [DIV_BITS-1:0] rem_d;

  // divisor stays put for the whole operation; remainder < divisor <= 2^31
  assign trial_d = {rem_q, dvd_q[DIV_BITS-1]};
  assign sub_d   = trial_d - {1'b0, req_i.divisor};
  assign rem_d   = sub_d[DIV_BITS] ? trial_d[DIV_BITS-1:0] : sub_d[DIV_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_BITS);
        dvd_q  <= req_i.dividend;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- design/shuffled_lcg_random_range.sv -----
// ----------------------------------------------------------------------------
// shuffled_lcg_random_range
// Random integer in a signed range from a shuffled Park-Miller generator.
// ----------------------------------------------------------------------------
// Sequence: an empty range returns low with no draw; other ranges run a pending
//   warm-up first, then draws; a span up to 2^31 adds two remainder passes
//   (rejection limit, final reduction); a rejection redraws.
// Flow: one request at a time; bit-serial remainder; MUL then RED per generator step.
// Reset: control, seed (1) and generator state clear at once; the shuffle
//   memory is not cleared, warm-up fills it before its first read.

module shuffled_lcg_random_range import slrr_pkg::*; #(
  parameter int SHUFFLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slrr_cfg_if.sink    cfg_i,
  slrr_req_if.sink    req_i,
  slrr_rsp_if.source  rsp_o
);

  localparam int IDX_W      = $clog2(SHUFFLE_DEPTH);
  localparam int WARM_STEPS = SHUFFLE_DEPTH + WARMUP_EXTRA;
  localparam int CNT_W      = $clog2(WARM_STEPS);
  // width of one slot of the 31-bit output space
  localparam int SLOT_DIV   = 1 + (int'(PM_MOD) - 1) / SHUFFLE_DEPTH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_W_MUL,
    ST_W_RED,
    ST_LIM_START,
    ST_LIM_WAIT,
    ST_D_MUL,
    ST_D_RED,
    ST_D_WB,
    ST_D_CHK,
    ST_MOD_WAIT,
    ST_DONE
  } state_e;

  state_e state_q;

  // request and range
  logic [31:0] lo_q;
  logic [31:0] hi_q;
  logic [31:0] span_q;     // hi - lo + 1, only used when <= 2^31
  logic        wide_q;     // span above 2^31: every draw is taken
  logic [30:0] limit_q;    // largest accepted draw

  // generator
  logic [30:0] seed_q;
  logic        warm_pending_q;
  logic [30:0] lcg_q;
  logic [45:0] prod_q;
  logic [CNT_W-1:0] cnt_q;
  logic [30:0] last_draw_q;
  logic [30:0] draw_q;
  logic [IDX_W-1:0] slot_q;

  // result
  logic [31:0] res_q;
  logic        rsp_valid_q;
  logic [31:0] rsp_value_q;

  // remainder unit
  logic          div_start_q;
  logic [31:0]   div_dividend_q;
  slrr_div_req_t div_req;
  slrr_div_rsp_t div_rsp;

  // shuffle memory
  logic [30:0]      shuf_mem [SHUFFLE_DEPTH];
  logic [30:0]      mem_rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [30:0]      mem_wdata;
  logic             mem_re;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic [32:0]      diff_d;
  logic [31:0]      fold_d;
  logic [30:0]      lcg_red_d;
  logic [30:0]      seed_fix_d;
  logic [IDX_W-1:0] slot_d;
  logic             req_acc;

  assign req_acc = req_i.valid && req_i.ready;

  // signed hi - lo, 33 bits; negative means empty range
  assign diff_d = {hi_q[31], hi_q} - {lo_q[31], lo_q};

  // x*16807 mod 2^31-1: fold high bits onto low bits, one correction
  assign fold_d    = {1'b0, prod_q[30:0]} + {17'd0, prod_q[45:31]};
  assign lcg_red_d = (fold_d >= {1'b0, PM_MOD}) ? 31'(fold_d - {1'b0, PM_MOD})
                                                : fold_d[30:0];

  // zero or the modulus would lock the generator
  assign seed_fix_d = ((seed_q == '0) || (seed_q == PM_MOD)) ? 31'd1 : seed_q;

  // slot = last_draw / SLOT_DIV against constant thresholds
  always_comb begin
    slot_d = '0;
    for (int k = 1; k < SHUFFLE_DEPTH; k++) begin
      if ({1'b0, last_draw_q} >= 32'(k * SLOT_DIV)) begin
        slot_d = IDX_W'(k);
      end
    end
  end

  // memory access per state: fill in W_RED, read in D_RED, write back in D_WB
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = lcg_q;
    mem_re    = 1'b0;
    case (state_q)
      ST_W_RED: begin
        // last SHUFFLE_DEPTH warm-up steps fill from the top slot down
        if (cnt_q < CNT_W'(SHUFFLE_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IDX_W-1:0];
          mem_wdata = lcg_red_d;
        end
      end
      ST_D_RED: begin
        mem_re = 1'b1;
      end
      ST_D_WB: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      shuf_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= shuf_mem[slot_q];
    end
  end

  // ---------------------------------------------------------------------------
  // remainder unit, shared by limit and final reduction
  // ---------------------------------------------------------------------------
  assign div_req.start    = div_start_q;
  assign div_req.dividend = div_dividend_q;
  assign div_req.divisor  = span_q;

  slrr_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      lo_q           <= '0;
      hi_q           <= '0;
      span_q         <= '0;
      wide_q         <= 1'b0;
      limit_q        <= '0;
      seed_q         <= 31'd1;
      warm_pending_q <= 1'b1;
      lcg_q          <= '0;
      prod_q         <= '0;
      cnt_q          <= '0;
      last_draw_q    <= '0;
      draw_q         <= '0;
      slot_q         <= '0;
      res_q          <= '0;
      rsp_valid_q    <= 1'b0;
      rsp_value_q    <= '0;
      div_start_q    <= 1'b0;
      div_dividend_q <= '0;
    end else begin
      div_start_q <= 1'b0;
      slot_q      <= slot_d;   // settles in the cycle after last_draw changes

      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      // seed write re-arms warm-up; user must write it only while idle; not enforced
      if (cfg_i.valid) begin
        seed_q         <= cfg_i.seed;
        warm_pending_q <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            lo_q    <= req_i.range_low;
            hi_q    <= req_i.range_high;
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          wide_q <= diff_d[31];
          span_q <= {1'b0, diff_d[30:0]} + 32'd1;
          if (diff_d[32]) begin
            // empty range: answer low, generator untouched
            res_q   <= lo_q;
            state_q <= ST_DONE;
          end else if (warm_pending_q) begin
            lcg_q   <= seed_fix_d;
            cnt_q   <= CNT_W'(WARM_STEPS - 1);
            state_q <= ST_W_MUL;
          end else begin
            state_q <= ST_LIM_START;
          end
        end

        ST_W_MUL: begin
          prod_q  <= lcg_q * PM_MULT;
          state_q <= ST_W_RED;
        end

        ST_W_RED: begin
          lcg_q <= lcg_red_d;
          if (cnt_q == '0) begin
            last_draw_q    <= lcg_red_d;
            warm_pending_q <= 1'b0;
            state_q        <= ST_LIM_START;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_W_MUL;
          end
        end

        ST_LIM_START: begin
          if (wide_q) begin
            state_q <= ST_D_MUL;
          end else begin
            div_start_q    <= 1'b1;
            div_dividend_q <= HALF_RANGE;
            state_q        <= ST_LIM_WAIT;
          end
        end

        ST_LIM_WAIT: begin
          if (div_rsp.done) begin
            // limit = 2^31 - 1 - (2^31 mod span)
            limit_q <= PM_MOD - div_rsp.remainder[30:0];
            state_q <= ST_D_MUL;
          end
        end

        ST_D_MUL: begin
          prod_q  <= lcg_q * PM_MULT;
          state_q <= ST_D_RED;
        end

        ST_D_RED: begin
          lcg_q   <= lcg_red_d;
          state_q <= ST_D_WB;
        end

        ST_D_WB: begin
          // old slot content is the draw; new generator value replaces it
          last_draw_q <= mem_rdata_q;
          draw_q      <= mem_rdata_q;
          state_q     <= ST_D_CHK;
        end

        ST_D_CHK: begin
          if (wide_q) begin
            res_q   <= lo_q + {1'b0, draw_q};
            state_q <= ST_DONE;
          end else if (draw_q > limit_q) begin
            state_q <= ST_D_MUL;   // reject, draw again
          end else begin
            div_start_q    <= 1'b1;
            div_dividend_q <= {1'b0, draw_q};
            state_q        <= ST_MOD_WAIT;
          end
        end

        ST_MOD_WAIT: begin
          if (div_rsp.done) begin
            res_q   <= lo_q + {1'b0, div_rsp.remainder[30:0]};
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_value_q <= res_q;
            rsp_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.random_value = signed'(rsp_value_q);

endmodule

// ----- design/slrr_checker.sv -----
// ----------------------------------------------------------------------------
// slrr_checker
// Port-level checks of the range generator, bound to the top level.
// ----------------------------------------------------------------------------
module slrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_value_i
);

  logic [1:0] pend_q;   // requests accepted, results not yet taken
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i))
    else $error("result dropped or changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while another is in work");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("result without a request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many requests outstanding");

endmodule

bind shuffled_lcg_random_range slrr_checker u_slrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.random_value)
);

// ----- test/shuffled_lcg_random_range_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lcg_random_range_tb
// Self-checking bench for the shuffled Park-Miller range generator. A short
// table of directed ranges is followed by random ranges over several seeds.
// Every request is run through a local model of the generator and shuffle
// table. Each result is checked in order against its prediction or typed value.
// ----------------------------------------------------------------------------

module shuffled_lcg_random_range_tb;

  // --------------------------------------------------------------------------
  // Bench constants
  // --------------------------------------------------------------------------
  localparam int              DEPTH      = 32;              // shuffle table size
  localparam longint unsigned PARK_MULT  = 64'd16807;
  localparam longint unsigned PARK_MOD   = 64'h7FFF_FFFF;   // 2^31 - 1
  localparam longint unsigned TWO_31     = 64'h8000_0000;
  localparam longint unsigned TWO_32     = 64'h1_0000_0000;
  localparam longint          MOST_NEG   = -longint'(TWO_31);
  // Each table slot covers this much of the generator's output range
  localparam longint unsigned SLOT_WIDTH = 1 + (PARK_MOD - 1) / DEPTH;

  localparam int CLK_HALF     = 6;    // 12 ns period
  localparam int DIR_COUNT    = 19;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 135;
  // Settle time after the last result before a seed write or the verdict.
  localparam int SETTLE_CYCLES = 16;

  // Handshake pacing of one phase
  typedef enum logic [1:0] {
    PACE_FREE,       // no idling on either side
    PACE_SRC_IDLE,   // requester idles on 86 percent of its draws
    PACE_SNK_STALL,  // result side stalls on 86 percent of its draws
    PACE_BOTH        // both sides at 33 percent
  } pace_e;

  // One directed row. The expected value is typed in only where it is
  // obvious (empty range, single-value range); other rows use the model.
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               typed;
    logic signed [31:0] want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  slrr_req_if req_if ();
  slrr_rsp_if rsp_if ();
  slrr_cfg_if cfg_if ();

  shuffled_lcg_random_range #(
    .SHUFFLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Generator model: seed register, generator value, last table output,
  // the shuffle table and the warm-up flag
  // --------------------------------------------------------------------------
  logic [30:0] seed_q;
  logic [30:0] gen_q;
  logic [30:0] prev_q;
  logic [30:0] tbl_q [DEPTH];
  logic        warm_q;

  int n_rejects;
  int n_draws;

  // One Park-Miller step, x * 16807 mod (2^31 - 1)
  function automatic logic [30:0] park_step(logic [30:0] x);
    longint unsigned prod;
    prod = 64'(x) * PARK_MULT;
    return 31'(prod % PARK_MOD);
  endfunction

  // Warm-up: DEPTH+8 steps from the seed, the last DEPTH of them fill the
  // table from the top slot down. A seed of 0 or 2^31-1 would stick the
  // generator, so those start from 1.
  function automatic void fill_shuffle();
    logic [30:0] x;
    x = seed_q;
    if (x == 31'd0 || x == 31'h7FFF_FFFF) x = 31'd1;
    for (int i = DEPTH + 7; i >= 0; i--) begin
      x = park_step(x);
      if (i < DEPTH) tbl_q[i] = x;
    end
    gen_q  = x;
    prev_q = tbl_q[0];
    warm_q = 1'b0;
  endfunction

  // One shuffled draw: the previous output picks the slot, the slot's old
  // content goes out and the fresh generator value takes its place
  function automatic logic [30:0] shuffled_draw();
    longint unsigned slot;
    if (warm_q) fill_shuffle();
    gen_q = park_step(gen_q);
    slot  = prev_q / SLOT_WIDTH;
    if (slot >= DEPTH) slot = DEPTH - 1;
    prev_q      = tbl_q[slot];
    tbl_q[slot] = gen_q;
    n_draws++;
    return prev_q;
  endfunction

  // Value the block should return for one request
  function automatic logic [31:0] predict_in_range(logic signed [31:0] lo,
                                                   logic signed [31:0] hi);
    longint          span;
    longint unsigned lim;
    logic [31:0]     r;
    // empty range: low comes back, no draw and no warm-up
    if (hi < lo) return lo;
    span = longint'(hi) - longint'(lo) + 1;
    if (span > TWO_31) begin
      // wide span: every draw fits
      r = {1'b0, shuffled_draw()};
    end else begin
      // reject draws at or above the largest multiple of the span up to 2^31
      lim = PARK_MOD - (TWO_31 % span);
      r   = {1'b0, shuffled_draw()};
      while (r > lim) begin
        n_rejects++;
        r = {1'b0, shuffled_draw()};
      end
      r = 32'(r % span);
    end
    return lo + r;
  endfunction

  // --------------------------------------------------------------------------
  // Expected results, oldest first, and the result checker
  // --------------------------------------------------------------------------
  logic [31:0] want_values [$];
  int          outstanding;
  int          n_checked;
  int          n_errors;
  int          n_requests;
  int          n_empty;
  int          n_seeds;

  // Hard stop, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("[%0t] timeout: %0d results still outstanding", $time, outstanding);
    $display("shuffled_lcg_random_range_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    logic [31:0] exp_val;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (want_values.size() == 0) begin
        $display("[%0t] unexpected result: expected none, got %0d (0x%08h)",
                 $time, rsp_if.random_value, rsp_if.random_value);
        n_errors++;
      end else begin
        exp_val = want_values.pop_front();
        outstanding--;
        n_checked++;
        if (rsp_if.random_value !== exp_val) begin
          $display("[%0t] random_value mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                   $time, $signed(exp_val), exp_val, rsp_if.random_value,
                   rsp_if.random_value);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready follows the stall rate of the current phase
  // --------------------------------------------------------------------------
  int src_idle_pct;
  int snk_stall_pct;

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic set_pace(pace_e pace);
    case (pace)
      PACE_FREE: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      PACE_SRC_IDLE: begin
        src_idle_pct  = 86;
        snk_stall_pct = 0;
      end
      PACE_SNK_STALL: begin
        src_idle_pct  = 0;
        snk_stall_pct = 86;
      end
      default: begin
        src_idle_pct  = 33;
        snk_stall_pct = 33;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Valid stays high from one request into the next when no idle gap is
  // drawn, so it is never lowered and raised within one time step.
  task automatic issue_request(logic signed [31:0] lo, logic signed [31:0] hi,
                               logic typed, logic signed [31:0] want);
    logic [31:0] model_val;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    model_val = predict_in_range(lo, hi);
    want_values.push_back(typed ? want : model_val);
    outstanding++;
    if (hi < lo) n_empty++;
    req_if.valid      <= 1'b1;
    req_if.range_low  <= lo;
    req_if.range_high <= hi;
    do @(posedge clk); while (!req_if.ready);
    n_requests++;
  endtask

  // Seed write, only once the block has gone quiet
  task automatic write_seed(logic [30:0] value);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.seed  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    seed_q = value;
    warm_q = 1'b1;
    n_seeds++;
  endtask

  // Seed of each random phase: the out-of-range pair, both ends of the
  // legal range, then random values
  function automatic logic [30:0] phase_seed(int p);
    case (p)
      0:       return 31'd0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'd1;
      3:       return 31'h7FFF_FFFE;
      default: return 31'($urandom_range(32'h7FFF_FFFE, 1));
    endcase
  endfunction

  // Random range. Picks are small spans, single values, empty ranges, placed spans
  // (wide, near a power of two, anything) and raw 32-bit pairs, which
  // come out empty about half the time.
  task automatic pick_range(output logic signed [31:0] lo,
                            output logic signed [31:0] hi);
    longint span;
    longint base;
    logic   placed;
    placed = 1'b0;
    span   = 1;
    case ($urandom_range(9))
      0, 1: begin
        lo = $urandom;
        hi = lo + $urandom_range(255);
      end
      2: begin
        lo = $urandom;
        hi = lo;
      end
      3: begin
        lo = $urandom;
        hi = lo - 1 - $urandom_range(16'hFFFF);
      end
      4: begin
        span   = longint'(TWO_31) + 1 + longint'(64'($urandom_range(32'h7FFF_FFFF)));
        placed = 1'b1;
      end
      5: begin
        // near 2^k: just above a power of two the rejection rate peaks
        span   = (64'sd1 <<< $urandom_range(31)) + $urandom_range(2);
        placed = 1'b1;
      end
      6: begin
        span   = 1 + longint'(64'($urandom_range(32'hFFFF_FFFF)));
        placed = 1'b1;
      end
      default: begin
        lo = $urandom;
        hi = $urandom;
      end
    endcase
    if (placed) begin
      base = MOST_NEG + longint'(64'($urandom_range(32'(longint'(TWO_32) - span))));
      lo   = 32'(base);
      hi   = 32'(base + span - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [DIR_COUNT];

  initial begin
    dir_rows = '{
      // empty range ahead of the first draw: no warm-up may start
      '{32'sd5,         32'sd4,         1'b1, 32'sd5},
      // empty range across the signed extremes
      '{32'h7FFF_FFFF,  32'h8000_0000,  1'b1, 32'h7FFF_FFFF},
      // single value at each extreme; the first one runs the warm-up
      '{32'h8000_0000,  32'h8000_0000,  1'b1, 32'h8000_0000},
      '{32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b1, 32'h7FFF_FFFF},
      // full span, then wide spans just above 2^31
      '{32'h8000_0000,  32'h7FFF_FFFF,  1'b0, 32'sd0},
      '{32'h8000_0000,  32'h0000_0001,  1'b0, 32'sd0},
      '{32'hFFFF_FFFF,  32'h7FFF_FFFF,  1'b0, 32'sd0},
      // span exactly 2^31: no rejection possible
      '{32'h0000_0000,  32'h7FFF_FFFF,  1'b0, 32'sd0},
      '{32'h8000_0000,  32'hFFFF_FFFF,  1'b0, 32'sd0},
      // span 2^30+1: about half the draws are rejected
      '{32'h0000_0000,  32'h4000_0000,  1'b0, 32'sd0},
      '{32'hC000_0000,  32'h0000_0000,  1'b0, 32'sd0},
      // small spans around zero
      '{32'hFFFF_FFFF,  32'h0000_0000,  1'b0, 32'sd0},
      '{32'sd10,        32'sd12,        1'b0, 32'sd0},
      '{-32'sd1000,     32'sd1000,      1'b0, 32'sd0},
      // small spans hugging each end
      '{32'h7FFF_FF00,  32'h7FFF_FFFF,  1'b0, 32'sd0},
      '{32'h8000_0000,  32'h8000_00FF,  1'b0, 32'sd0},
      // empty ranges with high negative
      '{32'h0000_0000,  32'hFFFF_FFFF,  1'b1, 32'h0000_0000},
      '{32'h5555_5555,  32'hAAAA_AAAA,  1'b1, 32'h5555_5555},
      // wide span, alternating bit patterns
      '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'sd0}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;

    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.range_low  <= '0;
    req_if.range_high <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.seed       <= '0;

    // model state after reset: seed 1, warm-up armed
    seed_q = 31'd1;
    gen_q  = '0;
    prev_q = '0;
    warm_q = 1'b1;
    for (int i = 0; i < DEPTH; i++) tbl_q[i] = '0;
    outstanding = 0;
    n_checked   = 0;
    n_errors    = 0;
    n_requests  = 0;
    n_empty     = 0;
    n_seeds     = 0;
    n_rejects   = 0;
    n_draws     = 0;
    set_pace(PACE_FREE);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows on the reset seed, back to back
    for (int r = 0; r < DIR_COUNT; r++) begin
      issue_request(dir_rows[r].lo, dir_rows[r].hi, dir_rows[r].typed, dir_rows[r].want);
    end
    req_if.valid <= 1'b0;

    // random phases, each on a fresh seed with its own pacing
    for (int p = 0; p < PHASES; p++) begin
      write_seed(phase_seed(p));
      set_pace(pace_e'(p % 4));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick_range(lo, hi);
        issue_request(lo, hi, 1'b0, 32'sd0);
      end
      req_if.valid <= 1'b0;
    end

    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d empty) on %0d seed writes and four pacing modes",
             n_requests, n_empty, n_seeds);
    $display("compared %0d results; model took %0d draws, %0d of them rejected",
             n_checked, n_draws, n_rejects);
    if (n_errors == 0) begin
      $display("shuffled_lcg_random_range_tb OK");
    end else begin
      $display("shuffled_lcg_random_range_tb NOT OK");
    end
    $finish;
  end

endmodule
